[hdl/pdr_pkg.sv]
// pdr_pkg: item types and constants shared by the poisson deviance residual pipeline
// no dependencies

package pdr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned DEV_W  = 48;
    localparam int unsigned POS_W  = 5;

    // ln 2 with 32 fraction bits, split into halves for the partial products
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // observation item as it enters
    typedef struct packed {
        logic [WORD_W-1:0] y_obs;
        logic [WORD_W-1:0] fitted_mean;
        logic [WORD_W-1:0] prior_weight;
    } obs_item_t;

    // result item as it leaves
    typedef struct packed {
        logic [DEV_W-1:0] deviance;
        logic             saturated;
        logic             invalid_mean;
    } res_item_t;

    // both logarithms in flight, with the operands they still need
    typedef struct packed {
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] mu;
        logic [WORD_W-1:0] wt;
        logic [POS_W-1:0]  p_y;
        logic [POS_W-1:0]  p_mu;
        logic [WORD_W-1:0] m_y;
        logic [WORD_W-1:0] m_mu;
        logic [WORD_W-1:0] f_y;
        logic [WORD_W-1:0] f_mu;
    } log_pair_t;

endpackage

[hdl/poisson_deviance_residual.sv]
// poisson_deviance_residual: 2*wt*(y*ln(y/mu) - (y - mu)) per item, fully pipelined,
// one item per cycle sustained while the output is not stalled, with one register stage
// per log2 squaring step and split 16-bit partial products
// reset clears every stage valid bit at once; no clearing pass, no other state
// depends on pdr_pkg, pdr_norm, pdr_log_step, pdr_tail

module poisson_deviance_residual #(
    parameter int unsigned FRAC_BITS      = 16,
    parameter int unsigned LOG_ITERATIONS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               obs_valid,
    output logic               obs_stall,
    input  pdr_pkg::obs_item_t obs,
    output logic               res_valid,
    input  logic               res_stall,
    output pdr_pkg::res_item_t res
);
    import pdr_pkg::*;

    // stage chain: normalise, one stage per squaring step, then the tail
    logic      pair_v  [LOG_ITERATIONS+1];
    log_pair_t pair    [LOG_ITERATIONS+1];
    logic      step_ld [LOG_ITERATIONS+1];
    logic      norm_ld;

    // each stage loads when empty or when the one after it loads,
    // so bubbles collapse and the input keeps flowing while a result waits, until every stage is full
    assign obs_stall = !norm_ld;

    pdr_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (obs_valid),
        .up_item    (obs),
        .ld         (norm_ld),
        .down_valid (pair_v[0]),
        .down       (pair[0]),
        .next_ld    (step_ld[0])
    );

    // squaring steps, fraction bits of both logs from the top down
    for (genvar k = 0; k < LOG_ITERATIONS; k++)
    begin : g_step
        pdr_log_step #(
            .STEP (k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (pair_v[k]),
            .up         (pair[k]),
            .ld         (step_ld[k]),
            .down_valid (pair_v[k+1]),
            .down       (pair[k+1]),
            .next_ld    (step_ld[k+1])
        );
    end

    // log difference through to saturation and the output register
    pdr_tail #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (pair_v[LOG_ITERATIONS]),
        .up        (pair[LOG_ITERATIONS]),
        .ld        (step_ld[LOG_ITERATIONS]),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

    // zero mean gives a clean zero result
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.invalid_mean |-> (res.deviance == '0) && !res.saturated)
        else $error("invalid mean with nonzero result");

    // a clipped result sits at full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturated |-> (&res.deviance) && !res.invalid_mean)
        else $error("saturated result not at full scale");

    // the input side only stalls when a result is waiting downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        obs_stall |-> res_valid && res_stall)
        else $error("input stalled with no waiting result");

endmodule

[hdl/pdr_norm.sv]
// pdr_norm: leading-one search and mantissa normalisation of y and mu
// depends on pdr_pkg

module pdr_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  pdr_pkg::obs_item_t  up_item,
    output logic                ld,
    output logic                down_valid,
    output pdr_pkg::log_pair_t  down,
    input  logic                next_ld
);
    import pdr_pkg::*;

    function automatic logic [POS_W-1:0] lead_one(input logic [WORD_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    logic      valid_reg;
    log_pair_t data_reg;
    log_pair_t data_next;

    assign ld = !valid_reg || next_ld;

    always_comb
    begin
        data_next      = '0;
        data_next.y    = up_item.y_obs;
        data_next.mu   = up_item.fitted_mean;
        data_next.wt   = up_item.prior_weight;
        data_next.p_y  = lead_one(up_item.y_obs);
        data_next.p_mu = lead_one(up_item.fitted_mean);
        data_next.m_y  = up_item.y_obs << (5'd31 - data_next.p_y);
        data_next.m_mu = up_item.fitted_mean << (5'd31 - data_next.p_mu);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down       = data_reg;

endmodule

[hdl/pdr_log_step.sv]
// pdr_log_step: one squaring step of the log2 fraction, for y and mu side by side
// depends on pdr_pkg

module pdr_log_step #(
    parameter int unsigned STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  pdr_pkg::log_pair_t  up,
    output logic                ld,
    output logic                down_valid,
    output pdr_pkg::log_pair_t  down,
    input  logic                next_ld
);
    import pdr_pkg::*;

    // fraction bit produced here, counted from the top
    localparam logic [POS_W-1:0] BIT_POS = POS_W'(31 - STEP);

    logic      valid_reg;
    log_pair_t data_reg;
    log_pair_t data_next;
    logic [63:0] sq_y;
    logic [63:0] sq_mu;

    assign ld = !valid_reg || next_ld;

    always_comb
    begin
        sq_y      = up.m_y * up.m_y;
        sq_mu     = up.m_mu * up.m_mu;
        data_next = up;
        // square is in [1,4) scaled by 2^62; renormalise into [1,2)
        if (sq_y[63])
        begin
            data_next.m_y           = sq_y[63:32];
            data_next.f_y[BIT_POS]  = 1'b1;
        end
        else
        begin
            data_next.m_y = sq_y[62:31];
        end
        if (sq_mu[63])
        begin
            data_next.m_mu          = sq_mu[63:32];
            data_next.f_mu[BIT_POS] = 1'b1;
        end
        else
        begin
            data_next.m_mu = sq_mu[62:31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down       = data_reg;

endmodule

[hdl/pdr_tail.sv]
// pdr_tail: log difference, ln 2 scaling, y product, inner term, weight product,
// saturation and the output register; depends on pdr_pkg

module pdr_tail #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  pdr_pkg::log_pair_t  up,
    output logic                ld,
    output logic                res_valid,
    output pdr_pkg::res_item_t  res,
    input  logic                res_stall
);
    import pdr_pkg::*;

    localparam logic [15:0] LN2_HI = LN2_Q32[31:16];
    localparam logic [15:0] LN2_LO = LN2_Q32[15:0];

    // stage valids
    logic d_v_reg, l_v_reg, n_v_reg, p_v_reg, q_v_reg, t_v_reg, w_v_reg, o_v_reg;
    logic d_ld, l_ld, n_ld, p_ld, q_ld, t_ld, w_ld, o_ld;

    // difference stage
    logic [37:0] d_mag_reg, d_mag_next;
    logic        d_neg_reg, d_neg_next;
    logic [31:0] d_y_reg, d_mu_reg, d_wt_reg;
    logic signed [6:0]  e_y, e_mu;
    logic signed [38:0] l_y, l_mu;
    logic signed [39:0] diff;

    // ln 2 partial products and sum
    logic [53:0] l_hi_reg, l_lo_reg;
    logic        l_neg_reg;
    logic [31:0] l_y_reg, l_mu_reg, l_wt_reg;
    logic [37:0] n_ln_reg;
    logic [53:0] n_sum;
    logic        n_neg_reg;
    logic [31:0] n_y_reg, n_mu_reg, n_wt_reg;

    // y partial products and sum
    logic [53:0] p_hi_reg, p_lo_reg;
    logic        p_neg_reg;
    logic [31:0] p_y_reg, p_mu_reg, p_wt_reg;
    logic [37:0] q_prod_reg;
    logic [53:0] q_sum;
    logic        q_neg_reg;
    logic [31:0] q_y_reg, q_mu_reg, q_wt_reg;

    // inner term and multiplicand
    logic signed [39:0] t_term;
    logic signed [39:0] t_signed_prod;
    logic [40:0] t_a_reg, t_a_next;
    logic        t_inv_reg, t_inv_next;
    logic [31:0] t_wt_reg;

    // weight partial products
    logic [56:0] w_hi_reg, w_lo_reg;
    logic        w_inv_reg;

    // output
    logic [72:0] o_full;
    logic [72:0] o_shift;
    res_item_t   o_item_reg, o_item_next;

    assign o_ld = !o_v_reg || !res_stall;
    assign w_ld = !w_v_reg || o_ld;
    assign t_ld = !t_v_reg || w_ld;
    assign q_ld = !q_v_reg || t_ld;
    assign p_ld = !p_v_reg || q_ld;
    assign n_ld = !n_v_reg || p_ld;
    assign l_ld = !l_v_reg || n_ld;
    assign d_ld = !d_v_reg || l_ld;
    assign ld   = d_ld;

    always_comb
    begin
        e_y   = $signed({2'b00, up.p_y}) - $signed(7'(FRAC_BITS));
        e_mu  = $signed({2'b00, up.p_mu}) - $signed(7'(FRAC_BITS));
        l_y   = {e_y, up.f_y};
        l_mu  = {e_mu, up.f_mu};
        diff  = 40'(l_y) - 40'(l_mu);
        d_neg_next = diff[39];
        d_mag_next = d_neg_next ? 38'(-diff) : 38'(diff);
    end

    assign n_sum = l_hi_reg + (l_lo_reg >> 16);
    assign q_sum = p_hi_reg + (p_lo_reg >> 16);

    always_comb
    begin
        t_signed_prod = q_neg_reg ? -$signed({2'b00, q_prod_reg})
                                  : $signed({2'b00, q_prod_reg});
        t_term = t_signed_prod - $signed({8'b0, q_y_reg}) + $signed({8'b0, q_mu_reg});
        t_inv_next = 1'b0;
        t_a_next   = '0;
        if (q_mu_reg == '0)
        begin
            t_inv_next = 1'b1;
        end
        else if (q_y_reg == '0)
        begin
            t_a_next = {8'b0, q_mu_reg, 1'b0};
        end
        else if (!t_term[39] && (t_term != '0))
        begin
            t_a_next = {t_term, 1'b0};
        end
    end

    always_comb
    begin
        o_full  = {w_hi_reg, 16'b0} + {16'b0, w_lo_reg};
        o_shift = o_full >> FRAC_BITS;
        o_item_next.invalid_mean = w_inv_reg;
        o_item_next.saturated    = |o_shift[72:48];
        o_item_next.deviance     = o_item_next.saturated ? '1 : o_shift[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
            n_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
            w_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (d_ld) d_v_reg <= up_valid;
            if (l_ld) l_v_reg <= d_v_reg;
            if (n_ld) n_v_reg <= l_v_reg;
            if (p_ld) p_v_reg <= n_v_reg;
            if (q_ld) q_v_reg <= p_v_reg;
            if (t_ld) t_v_reg <= q_v_reg;
            if (w_ld) w_v_reg <= t_v_reg;
            if (o_ld) o_v_reg <= w_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ld)
        begin
            d_mag_reg <= d_mag_next;
            d_neg_reg <= d_neg_next;
            d_y_reg   <= up.y;
            d_mu_reg  <= up.mu;
            d_wt_reg  <= up.wt;
        end
        if (l_ld)
        begin
            l_hi_reg  <= 54'(d_mag_reg) * 54'(LN2_HI);
            l_lo_reg  <= 54'(d_mag_reg) * 54'(LN2_LO);
            l_neg_reg <= d_neg_reg;
            l_y_reg   <= d_y_reg;
            l_mu_reg  <= d_mu_reg;
            l_wt_reg  <= d_wt_reg;
        end
        if (n_ld)
        begin
            n_ln_reg  <= 38'(n_sum >> 16);
            n_neg_reg <= l_neg_reg;
            n_y_reg   <= l_y_reg;
            n_mu_reg  <= l_mu_reg;
            n_wt_reg  <= l_wt_reg;
        end
        if (p_ld)
        begin
            p_hi_reg  <= 54'(n_ln_reg) * 54'(n_y_reg[31:16]);
            p_lo_reg  <= 54'(n_ln_reg) * 54'(n_y_reg[15:0]);
            p_neg_reg <= n_neg_reg;
            p_y_reg   <= n_y_reg;
            p_mu_reg  <= n_mu_reg;
            p_wt_reg  <= n_wt_reg;
        end
        if (q_ld)
        begin
            q_prod_reg <= 38'(q_sum >> 16);
            q_neg_reg  <= p_neg_reg;
            q_y_reg    <= p_y_reg;
            q_mu_reg   <= p_mu_reg;
            q_wt_reg   <= p_wt_reg;
        end
        if (t_ld)
        begin
            t_a_reg   <= t_a_next;
            t_inv_reg <= t_inv_next;
            t_wt_reg  <= q_wt_reg;
        end
        if (w_ld)
        begin
            w_hi_reg  <= 57'(t_a_reg) * 57'(t_wt_reg[31:16]);
            w_lo_reg  <= 57'(t_a_reg) * 57'(t_wt_reg[15:0]);
            w_inv_reg <= t_inv_reg;
        end
        if (o_ld)
        begin
            o_item_reg <= o_item_next;
        end
    end

    assign res_valid = o_v_reg;
    assign res       = o_item_reg;

endmodule

[sim/pdr_checker.sv]
// pdr_checker: watches both channels of the deviance residual block, predicts and compares
// depends on pdr_pkg

module pdr_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               obs_valid,
    input  logic               obs_stall,
    input  pdr_pkg::obs_item_t obs,
    input  logic               res_valid,
    input  logic               res_stall,
    input  pdr_pkg::res_item_t res,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdr_pkg::*;

    localparam int FRAC = 16;
    localparam int ITERS = 20;
    localparam logic [63:0] DEV_TOP = (64'd1 << 48) - 64'd1;

    res_item_t expected_q[$];

    // floor(a*b / 2^s) for a 32-bit b, using a 16-bit split of b
    function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = a * ((b >> 16) & 64'hFFFF);
        lo = a * (b & 64'hFFFF);
        if (s >= 16)
            return (hi + (lo >> 16)) >> (s - 16);
        return (hi << (16 - s)) + (lo >> s);
    endfunction

    function automatic longint log2_fixed(logic [31:0] x);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 31;
        frac = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        m = 64'(x) << (31 - p);
        for (int i = 0; i < ITERS; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(p - FRAC) * 64'sd4294967296 + longint'(frac << (32 - ITERS));
    endfunction

    function automatic res_item_t residual_of(obs_item_t o);
        res_item_t r;
        logic [63:0] dev;
        longint diff;
        longint yl;
        longint term;
        logic [63:0] mag;
        logic [63:0] prod;
        r = '0;
        dev = 0;
        if (o.fitted_mean == 0)
            r.invalid_mean = 1'b1;
        else if (o.y_obs == 0)
            dev = mul_shr(2 * 64'(o.fitted_mean), 64'(o.prior_weight), FRAC);
        else
        begin
            diff = log2_fixed(o.y_obs) - log2_fixed(o.fitted_mean);
            mag = diff < 0 ? 64'(-diff) : 64'(diff);
            prod = mul_shr(mul_shr(mag, 64'(LN2_Q32), 32), 64'(o.y_obs), 32);
            yl = diff < 0 ? -longint'(prod) : longint'(prod);
            term = yl - (longint'(o.y_obs) - longint'(o.fitted_mean));
            if (term > 0)
                dev = mul_shr(2 * 64'(term), 64'(o.prior_weight), FRAC);
        end
        if (dev > DEV_TOP)
        begin
            dev = DEV_TOP;
            r.saturated = 1'b1;
        end
        r.deviance = dev[47:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        res_item_t want;
        if (!rst_n)
            fail_count <= 0;
        else
        begin
            if (obs_valid && !obs_stall)
                expected_q.push_back(residual_of(obs));
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.deviance !== res.deviance
                        || want.saturated !== res.saturated
                        || want.invalid_mean !== res.invalid_mean)
                    begin
                        $display("%0t: mismatch expected dev %h sat %b inv %b,",
                                 $time, want.deviance, want.saturated, want.invalid_mean);
                        $display("    actual dev %h sat %b inv %b",
                                 res.deviance, res.saturated, res.invalid_mean);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/tb.sv]
// tb: stimulus and verdict for the poisson deviance residual block
// depends on pdr_pkg, pdr_checker and the block itself

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdr_pkg::*;

    localparam int LATENCY = 29;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      obs_valid = 1'b0;
    logic      obs_stall;
    obs_item_t obs = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    int        sent = 0;
    // idle percentages for the sender and the receiver, changed per phase
    int        send_idle = 0;
    int        recv_idle = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    poisson_deviance_residual i_dut (
        .clk(clk), .rst_n(rst_n),
        .obs_valid(obs_valid), .obs_stall(obs_stall), .obs(obs),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    pdr_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .obs_valid(obs_valid), .obs_stall(obs_stall), .obs(obs),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog on total cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[poisson_deviance_residual] ERROR");
            $finish;
        end
    end

    // receiver stalls at random with the current percentage
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_idle);

    // random word shaped to hit small, mid, edge and full range values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0003_0000);
            2: return 32'h0001_0000 + $urandom_range(32'h0000_0FFF) - 32'h800;
            3: return {16'h0, 16'($urandom)};
            4: return 32'(1) << $urandom_range(31);
            default: return ~(32'($urandom_range(3)));
        endcase
    endfunction

    // present one item and hold it until accepted, with random idle gaps first
    task automatic send_item(logic [31:0] y, logic [31:0] mu, logic [31:0] wt);
        while ($urandom_range(99) < send_idle)
        begin
            obs_valid <= 1'b0;
            @(posedge clk);
        end
        obs_valid <= 1'b1;
        obs <= '{y_obs: y, fitted_mean: mu, prior_weight: wt};
        @(posedge clk);
        while (obs_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic random_items(int count);
        logic [31:0] y;
        logic [31:0] mu;
        repeat (count)
        begin
            y = pick_word();
            // mu near y often, so the log difference stays small and results sensible
            mu = ($urandom_range(2) == 0) ? y + 32'($urandom_range(64)) - 32'd32 : pick_word();
            if ($urandom_range(30) == 0)
                mu = 0;
            if ($urandom_range(20) == 0)
                y = 0;
            send_item(y, mu, pick_word());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero mean, zero observation, near-equal values, overflow
        send_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(32'h0, 32'h0, 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
        send_item(32'h0, 32'h0002_0000, 32'h0001_0000);
        send_item(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h0000_0001, 32'h0000_0001, 32'h0);
        send_item(32'h0001_0001, 32'h0001_0000, 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0001_0001, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h0000_8000, 32'h0100_0000);
        send_item(32'h0000_8000, 32'h8000_0000, 32'h0001_0000);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        random_items(300);
        send_idle = 67;
        random_items(270);
        send_idle = 0;
        recv_idle = 67;
        random_items(270);
        send_idle = 22;
        recv_idle = 22;
        random_items(270);
        obs_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        recv_idle = 0;
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d items: extremes, zero mean and zero observation cases,", sent);
        $display("random operands under free flow, sender gaps, receiver stalls and both");
        if (fail_count == 0)
            $display("[poisson_deviance_residual] OK");
        else
            $display("[poisson_deviance_residual] ERROR");
        $finish;
    end
endmodule
